// File: rtl/core/upq_pkg.sv
// types and constants shared by the unsorted priority queue files
package upq_pkg;

  localparam int KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 7;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [STATUS_W-1:0]     status;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic first;
  } cmp_ctrl_t;

endpackage

// File: rtl/core/upq_mem.sv
// key store: one write port and one registered read port
module upq_mem #(
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [ADDR_W-1:0]               wr_addr,
  input  logic signed [upq_pkg::KEY_W-1:0] wr_data,
  input  logic                            rd_en,
  input  logic [ADDR_W-1:0]               rd_addr,
  output logic signed [upq_pkg::KEY_W-1:0] rd_data
);

  logic signed [upq_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/upq_min.sv
// shared signed compare unit tracking the smallest key seen in a scan
module upq_min #(
  parameter int IDX_W = 6
) (
  input  logic                             clk,
  input  upq_pkg::cmp_ctrl_t               ctrl,
  input  logic signed [upq_pkg::KEY_W-1:0] key,
  input  logic [IDX_W-1:0]                 idx,
  output logic signed [upq_pkg::KEY_W-1:0] best_key,
  output logic [IDX_W-1:0]                 best_idx
);

  logic take;

  // strict less keeps the earliest of equal keys
  assign take = ctrl.first || (key < best_key);

  always_ff @(posedge clk) begin
    if (ctrl.valid && take) begin
      best_key <= key;
      best_idx <= idx;
    end
  end

endmodule

// File: rtl/core/unsorted_priority_queue.sv
// unsorted priority queue top level: sequencer, key store and compare unit
//
// Min-priority queue of signed 32-bit keys held unsorted in a RAM.
// Input channel in_valid/in_stall/in_data carries func (insert or
// remove-min) and key_in; output channel out_valid/out_stall/out_data
// returns key_out, status and occupancy, exactly one result per transfer.
// An insert writes the key at the end of the store; its result is held in
// S_WAIT until the output register is free, then loaded into it.
// A remove-min on n stored keys reads the RAM once per key through its
// single read port, feeding one signed comparator, then moves the last key
// into the freed slot; the scan runs through S_SCAN, S_DRAIN and S_MOVE, and
// the result then waits in S_WAIT. Removal from an empty queue and insert
// into a full one answer with an error status and no scan.
// in_stall is high from a transfer until its result is in the output
// register, so no new request is taken while one is still in progress.
// A finished result waits in the output register while out_stall is high;
// the next input transfer is still taken, and its result waits internally.
// Reset (rst, synchronous) empties the queue and clears both valids; the
// RAM is not cleared, as only written entries are ever read.
module unsorted_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  upq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output upq_pkg::out_item_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_MOVE  = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic cmp_valid;
  logic signed [upq_pkg::KEY_W-1:0] last_key;
  upq_pkg::out_item_t res;

  logic in_xfer;
  logic out_free;
  logic out_load;
  logic [IDX_W-1:0] last_idx;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic signed [upq_pkg::KEY_W-1:0] wr_data;
  logic rd_en;
  logic signed [upq_pkg::KEY_W-1:0] rd_data;
  logic signed [upq_pkg::KEY_W-1:0] best_key;
  logic [IDX_W-1:0] best_idx;
  upq_pkg::cmp_ctrl_t ctrl;
  logic is_full;

  assign in_stall = (state != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_WAIT) && out_free;
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign is_full = (count >= CNT_W'(CAPACITY));

  assign rd_en = (state == S_SCAN);
  assign ctrl.valid = cmp_valid;
  assign ctrl.first = (cmp_idx == '0);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = best_idx;
    wr_data = last_key;
    if (state == S_MOVE) begin
      wr_en = 1'b1;
    end else if (in_xfer && (in_data.func == upq_pkg::FUNC_INSERT) && !is_full) begin
      wr_en = 1'b1;
      wr_addr = IDX_W'(count);
      wr_data = in_data.key_in;
    end
  end

  upq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  upq_min #(
    .IDX_W (IDX_W)
  ) u_min (
    .clk      (clk),
    .ctrl     (ctrl),
    .key      (rd_data),
    .idx      (cmp_idx),
    .best_key (best_key),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_valid <= (state == S_SCAN);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res.key_out <= '0;
            if (in_data.func == upq_pkg::FUNC_INSERT) begin
              state <= S_WAIT;
              if (is_full) begin
                res.status <= upq_pkg::ST_FULL;
                res.occupancy <= upq_pkg::OCC_W'(count);
              end else begin
                count <= count + CNT_W'(1);
                res.status <= upq_pkg::ST_OK;
                res.occupancy <= upq_pkg::OCC_W'(count + CNT_W'(1));
              end
            end else if (count == '0) begin
              state <= S_WAIT;
              res.status <= upq_pkg::ST_EMPTY;
              res.occupancy <= upq_pkg::OCC_W'(count);
            end else begin
              scan_idx <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_idx <= scan_idx;
          if (scan_idx == last_idx) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // data of the last entry is compared now
          last_key <= rd_data;
          state <= S_MOVE;
        end
        S_MOVE: begin
          // last key fills the slot of the removed one
          count <= count - CNT_W'(1);
          res.key_out <= best_key;
          res.status <= upq_pkg::ST_OK;
          res.occupancy <= upq_pkg::OCC_W'(count - CNT_W'(1));
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
